// ===== sv/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
// Used by greedy_box_suppression, gbs_pair_pipe and gbs_chk; no dependencies.
`default_nettype none

package gbs_pkg;

	localparam logic [8:0] THR_RESET = 9'd115;

	typedef struct packed {
		logic               first;
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic        [14:0] box_width;
		logic        [14:0] box_height;
	} box_t;

	typedef struct packed {
		logic        keep;
		logic [15:0] box_index;
		logic [6:0]  kept_count;
		logic        overflow;
	} result_t;

	// one stored box with its precomputed area
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic        [14:0] w;
		logic        [14:0] h;
		logic        [29:0] area;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_AREA = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic area_mode;
		logic ent_valid;
	} pipe_ctl_t;

	typedef struct packed {
		logic active;
		logic hit;
	} pipe_stat_t;

endpackage

`default_nettype wire

// ===== sv/gbs_pair_pipe.sv =====
// Pairwise overlap test pipeline: one stored box against the current box per cycle.
// Holds the shared multiplier; depends on gbs_pkg.
`default_nettype none

module gbs_pair_pipe import gbs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire box_t        ref_box,
	input  wire logic [29:0] ref_area,
	input  wire logic [8:0]  thr,
	input  wire pipe_ctl_t   ctl,
	input  wire entry_t      ent,
	output logic [29:0]      area,
	output pipe_stat_t       stat
);

	function automatic logic [14:0] overlap_len(
		input logic signed [15:0] a0,
		input logic        [14:0] alen,
		input logic signed [15:0] b0,
		input logic        [14:0] blen
	);
		logic signed [16:0] ea;
		logic signed [16:0] eb;
		logic signed [16:0] lo;
		logic signed [16:0] hi;
		logic signed [17:0] diff;
		ea = 17'(a0) + $signed({2'b00, alen});
		eb = 17'(b0) + $signed({2'b00, blen});
		lo = (a0 > b0) ? 17'(a0) : 17'(b0);
		hi = (ea < eb) ? ea : eb;
		diff = 18'(hi) - 18'(lo);
		// a positive overlap never exceeds the shorter side
		overlap_len = (diff > 18'sd0) ? diff[14:0] : 15'd0;
	endfunction

	logic        v_s2, v_s3, v_s4, v_s5;
	logic [14:0] ox_s2, oy_s2;
	logic [29:0] aj_s2, aj_s3;
	logic [29:0] inter_s3, inter_s4, inter_s5;
	logic [30:0] uni_s4;
	logic [39:0] prod_s5;
	logic [14:0] mul_a, mul_b;
	logic [29:0] mul_p;

	// shared multiplier: box area while setting up, pair intersection while scanning
	always_comb begin
		mul_a = ctl.area_mode ? ref_box.box_width  : ox_s2;
		mul_b = ctl.area_mode ? ref_box.box_height : oy_s2;
		mul_p = mul_a * mul_b;
	end

	assign area = mul_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= ctl.ent_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ox_s2    <= overlap_len(ref_box.box_x, ref_box.box_width, ent.x, ent.w);
		oy_s2    <= overlap_len(ref_box.box_y, ref_box.box_height, ent.y, ent.h);
		aj_s2    <= ent.area;
		inter_s3 <= mul_p;
		aj_s3    <= aj_s2;
		uni_s4   <= 31'(ref_area) + 31'(aj_s3) - 31'(inter_s3);
		inter_s4 <= inter_s3;
		prod_s5  <= 40'(thr) * 40'(uni_s4);
		inter_s5 <= inter_s4;
	end

	always_comb begin
		stat.active = v_s2 | v_s3 | v_s4 | v_s5;
		stat.hit    = v_s5 && ({2'b00, inter_s5, 8'h00} > prod_s5);
	end

endmodule

`default_nettype wire

// ===== sv/greedy_box_suppression.sv =====
// Greedy non-maximum suppression by intersection over union, top level.
// Holds the sequencer and the kept-box store; depends on gbs_pkg and gbs_pair_pipe.
//
//   channel  | signals                       | beat taken when
//   ---------+-------------------------------+-------------------------
//   input    | start, busy, box              | start && !busy
//   result   | done, result                  | done (one cycle, no stall)
//   config   | cfg_valid, cfg_ready, cfg_data| cfg_valid && cfg_ready
//
// From start to done a box passes the area setup, then a scan in which one
// stored box enters the overlap pipeline per cycle, for each of the N boxes
// already kept in the set, then the pipeline drain. busy stays high for the
// whole item. Reset empties the set and loads the threshold with 115; the
// store itself is not cleared. Results cannot be stalled.
`default_nettype none

module greedy_box_suppression import gbs_pkg::*; #(
	parameter int MAX_KEPT = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire box_t       box,
	output logic            done,
	output result_t         result,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [8:0] cfg_data
);

	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = $clog2(MAX_KEPT + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_KEPT);

	state_t        state_q;
	box_t          box_q;
	logic [29:0]   area_q;
	logic [8:0]    thr_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] rd_q;
	logic [15:0]   pos_q;
	logic [15:0]   index_q;
	logic          sup_q;
	logic          done_q;
	result_t       result_q;
	entry_t        kept_mem_q [MAX_KEPT];
	entry_t        ent_s1;
	logic          v_s1;
	logic          accept;
	logic          rd_en;
	logic          store_full;
	logic          store_en;
	logic [29:0]   area;
	pipe_ctl_t     pctl;
	pipe_stat_t    pstat;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign result     = result_q;
	assign rd_en      = (state_q == ST_SCAN) && (rd_q < total_q);
	assign store_full = (total_q >= FULL_CNT);
	assign store_en   = (state_q == ST_DONE) && !sup_q && !store_full;

	always_comb begin
		pctl.area_mode = (state_q == ST_AREA);
		pctl.ent_valid = v_s1;
	end

	gbs_pair_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.ref_box  (box_q),
		.ref_area (area_q),
		.thr      (thr_q),
		.ctl      (pctl),
		.ent      (ent_s1),
		.area     (area),
		.stat     (pstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			pos_q   <= '0;
			rd_q    <= '0;
			sup_q   <= 1'b0;
			done_q  <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= rd_en;
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			if (pstat.hit) begin
				sup_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sup_q   <= 1'b0;
						rd_q    <= '0;
						state_q <= ST_AREA;
						if (box.first) begin
							total_q <= '0;
							pos_q   <= 16'd1;
						end else if (pos_q != 16'hFFFF) begin
							pos_q <= pos_q + 16'd1;
						end
					end
				end
				ST_AREA: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// all entries issued and the pipeline drained
					if (!rd_en && !v_s1 && !pstat.active) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (store_en) begin
						total_q <= total_q + 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_q   <= box;
			index_q <= box.first ? 16'd0 : pos_q;
		end
		if (state_q == ST_AREA) begin
			area_q <= area;
		end
		if (rd_en) begin
			ent_s1 <= kept_mem_q[rd_q[AW-1:0]];
		end
		if (store_en) begin
			kept_mem_q[total_q[AW-1:0]] <= '{x: box_q.box_x, y: box_q.box_y,
				w: box_q.box_width, h: box_q.box_height, area: area_q};
		end
		if (state_q == ST_DONE) begin
			result_q.keep       <= !sup_q;
			result_q.box_index  <= index_q;
			result_q.kept_count <= store_en ? 7'(total_q + 1'b1) : 7'(total_q);
			result_q.overflow   <= !sup_q && store_full;
		end
	end

endmodule

`default_nettype wire

// ===== sv/gbs_chk.sv =====
// Port-level assertions for greedy_box_suppression, bound to the top level.
// Depends on gbs_pkg.
`default_nettype none

module gbs_chk import gbs_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    done,
	input wire result_t result
);

	// an accepted beat holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted beat");

	// the result appears exactly as the block returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $fell(busy))
		else $error("result strobe without end of item");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item ended without result");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results for one item");

	a_ovf_keep: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> result.keep)
		else $error("overflow on a suppressed box");

endmodule

bind greedy_box_suppression gbs_chk u_gbs_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for greedy_box_suppression: directed table, then random box sets under
// several thresholds, each result checked against its typed table verdict or an in-bench
// IoU suppression predictor. Depends on gbs_pkg and the greedy_box_suppression RTL.

module tb import gbs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_KEPT = 64;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	box_t       box_in;
	logic       done;
	result_t    result_out;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [8:0] cfg_data;

	greedy_box_suppression #(.MAX_KEPT(MAX_KEPT)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.box       (box_in),
		.done      (done),
		.result    (result_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	entry_t     kept_store [MAX_KEPT];
	int         kept_n;
	int         set_pos;
	logic [8:0] iou_limit;

	result_t expected_verdicts [$];
	result_t expected_now;

	int mismatch_count  = 0;
	int results_checked = 0;
	int boxes_sent      = 0;
	int sets_run        = 0;
	int thr_settings    = 0;
	int kept_seen       = 0;
	int dropped_seen    = 0;
	int overflow_seen   = 0;
	int sender_idle_pct = 32;

	typedef struct {
		int      thr;
		box_t    b;
		bit      typed;
		result_t want;
	} stim_row_t;

	stim_row_t directed_rows [$];

	function automatic box_t make_box(bit f, int x, int y, int w, int h);
		box_t b;
		b.first      = f;
		b.box_x      = x[15:0];
		b.box_y      = y[15:0];
		b.box_width  = w[14:0];
		b.box_height = h[14:0];
		return b;
	endfunction

	function automatic result_t make_verdict(bit k, int idx, int cnt, bit ov);
		result_t r;
		r.keep       = k;
		r.box_index  = idx[15:0];
		r.kept_count = cnt[6:0];
		r.overflow   = ov;
		return r;
	endfunction

	function automatic void add_row(int thr, box_t b, bit typed, result_t want);
		stim_row_t row;
		row.thr   = thr;
		row.b     = b;
		row.typed = typed;
		row.want  = want;
		directed_rows = {directed_rows, row};
	endfunction

	// overlap of half-open spans [a0, a0+alen) and [b0, b0+blen)
	function automatic longint span_overlap(longint a0, longint alen, longint b0, longint blen);
		longint lo, hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
		return (hi > lo) ? hi - lo : 64'sd0;
	endfunction

	function automatic result_t predict_verdict(box_t b);
		result_t r;
		longint  x, y, w, h, area, inter, uni;
		bit      keep_it, ov;
		x = longint'(b.box_x);
		y = longint'(b.box_y);
		w = longint'({1'b0, b.box_width});
		h = longint'({1'b0, b.box_height});
		area = w * h;
		keep_it = 1'b1;
		ov = 1'b0;
		if (b.first) begin
			kept_n  = 0;
			set_pos = 0;
		end
		r.box_index = set_pos[15:0];
		if (set_pos < 65535)
			set_pos++;
		for (int j = 0; j < kept_n; j++) begin
			inter = span_overlap(x, w, longint'(kept_store[j].x),
				longint'({1'b0, kept_store[j].w}))
				* span_overlap(y, h, longint'(kept_store[j].y),
				longint'({1'b0, kept_store[j].h}));
			uni = area + longint'({1'b0, kept_store[j].area}) - inter;
			if (inter * 256 > longint'({1'b0, iou_limit}) * uni)
				keep_it = 1'b0;
		end
		if (keep_it) begin
			if (kept_n < MAX_KEPT) begin
				kept_store[kept_n].x    = b.box_x;
				kept_store[kept_n].y    = b.box_y;
				kept_store[kept_n].w    = b.box_width;
				kept_store[kept_n].h    = b.box_height;
				kept_store[kept_n].area = area[29:0];
				kept_n++;
			end else begin
				ov = 1'b1;
			end
		end
		r.keep       = keep_it;
		r.kept_count = kept_n[6:0];
		r.overflow   = ov;
		if (ov)
			overflow_seen++;
		if (keep_it)
			kept_seen++;
		else
			dropped_seen++;
		return r;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("mismatch at result %0d, %s: got %0d, expected %0d",
				results_checked, what, got, want);
	endtask

	// one input beat; start stays high into the next item unless a gap is drawn
	task automatic send_box(box_t b, bit typed, result_t want);
		int      gap;
		result_t pred;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 80) : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start  <= 1'b1;
		box_in <= b;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pred = predict_verdict(b);
		expected_verdicts = {expected_verdicts, (typed ? want : pred)};
		boxes_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_verdicts.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_threshold(logic [8:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		iou_limit = v;
		thr_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// a few overlapping clusters, as a detector would produce
	task automatic run_cluster_set();
		int n_centers, len, c, w, h, x, y;
		int cx [4];
		int cy [4];
		int cw [4];
		int ch [4];
		n_centers = $urandom_range(1, 4);
		len = $urandom_range(4, 40);
		for (int i = 0; i < n_centers; i++) begin
			cx[i] = int'($urandom_range(0, 40000)) - 20000;
			cy[i] = int'($urandom_range(0, 40000)) - 20000;
			cw[i] = $urandom_range(16, 4000);
			ch[i] = $urandom_range(16, 4000);
		end
		for (int k = 0; k < len; k++) begin
			c = $urandom_range(0, n_centers - 1);
			x = cx[c] + int'($urandom_range(0, cw[c] / 2)) - cw[c] / 4;
			y = cy[c] + int'($urandom_range(0, ch[c] / 2)) - ch[c] / 4;
			w = cw[c] + int'($urandom_range(0, cw[c] / 2)) - cw[c] / 4;
			h = ch[c] + int'($urandom_range(0, ch[c] / 2)) - ch[c] / 4;
			if ($urandom_range(0, 15) == 0)
				w = 0;
			if ($urandom_range(0, 15) == 0)
				h = 0;
			send_box(make_box((k == 0) && ($urandom_range(0, 7) != 0), x, y, w, h),
				1'b0, '0);
		end
		sets_run++;
	endtask

	// mostly disjoint boxes on a grid, at times long enough to fill the store
	task automatic run_sparse_set();
		int   len, slot;
		box_t b;
		len = $urandom_range(60, 78);
		for (int k = 0; k < len; k++) begin
			if (k > 0 && $urandom_range(0, 9) == 0) begin
				b.first = 1'b0;
			end else begin
				slot = k % 81;
				b = make_box(k == 0,
					-32000 + (slot % 9) * 7000 + int'($urandom_range(0, 999)),
					-32000 + (slot / 9) * 7000 + int'($urandom_range(0, 999)),
					$urandom_range(1, 5000), $urandom_range(1, 5000));
			end
			send_box(b, 1'b0, '0);
		end
		sets_run++;
	endtask

	task automatic run_noise_set();
		int len, w, h;
		len = $urandom_range(3, 12);
		for (int k = 0; k < len; k++) begin
			w = $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 300);
			h = $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 300);
			send_box(make_box($urandom_range(0, 7) == 0, $urandom_range(0, 65535),
				$urandom_range(0, 65535), w, h), 1'b0, '0);
		end
		sets_run++;
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_verdicts.size() == 0) begin
				flag_mismatch("result with none expected", 1, 0);
			end else begin
				expected_now = expected_verdicts.pop_front();
				if (result_out.keep !== expected_now.keep)
					flag_mismatch("keep", result_out.keep, expected_now.keep);
				if (result_out.box_index !== expected_now.box_index)
					flag_mismatch("box_index", result_out.box_index, expected_now.box_index);
				if (result_out.kept_count !== expected_now.kept_count)
					flag_mismatch("kept_count", result_out.kept_count,
						expected_now.kept_count);
				if (result_out.overflow !== expected_now.overflow)
					flag_mismatch("overflow", result_out.overflow, expected_now.overflow);
			end
			results_checked++;
		end
	end

	initial begin
		int         sent_mark, pick;
		logic [8:0] phase_thr;
		arst_n    = 1'b0;
		start     = 1'b0;
		box_in    = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		kept_n    = 0;
		set_pos   = 0;
		iou_limit = THR_RESET;

		// reset threshold first, no first flag on the opening box
		add_row(-1, make_box(0, 0, 0, 160, 160), 1, make_verdict(1, 0, 1, 0));
		add_row(-1, make_box(0, 0, 0, 160, 160), 1, make_verdict(0, 1, 1, 0));
		add_row(-1, make_box(1, -32768, -32768, 32767, 32767), 1, make_verdict(1, 0, 1, 0));
		add_row(-1, make_box(0, 32767, 32767, 32767, 32767), 1, make_verdict(1, 1, 2, 0));
		add_row(-1, make_box(0, -32768, -32768, 32767, 32767), 1, make_verdict(0, 2, 2, 0));
		// zero-area boxes never suppress each other
		add_row(-1, make_box(1, 100, 100, 0, 0), 1, make_verdict(1, 0, 1, 0));
		add_row(-1, make_box(0, 100, 100, 0, 0), 1, make_verdict(1, 1, 2, 0));
		add_row(-1, make_box(0, 100, 100, 0, 32767), 1, make_verdict(1, 2, 3, 0));
		add_row(-1, make_box(1, 0, 0, 1600, 1600), 0, '0);
		add_row(-1, make_box(0, 800, 0, 1600, 1600), 0, '0);
		add_row(-1, make_box(0, 160, 0, 1600, 1600), 0, '0);
		add_row(-1, make_box(0, 1600, 1600, 1600, 1600), 0, '0);
		add_row(-1, make_box(0, 32767, -32768, 0, 32767), 0, '0);
		// zero threshold: any overlap suppresses, touching edges do not
		add_row(0, make_box(1, 0, 0, 1600, 1600), 1, make_verdict(1, 0, 1, 0));
		add_row(-1, make_box(0, 1599, 1599, 16, 16), 1, make_verdict(0, 1, 1, 0));
		add_row(-1, make_box(0, 1600, 0, 16, 16), 1, make_verdict(1, 2, 2, 0));
		// above 1.0 nothing is suppressed
		add_row(511, make_box(1, 0, 0, 1600, 1600), 1, make_verdict(1, 0, 1, 0));
		add_row(-1, make_box(0, 0, 0, 1600, 1600), 1, make_verdict(1, 1, 2, 0));
		// exactly 1.0: equal ratio is not above the limit
		add_row(256, make_box(1, 0, 0, 1600, 1600), 1, make_verdict(1, 0, 1, 0));
		add_row(-1, make_box(0, 0, 0, 1600, 1600), 1, make_verdict(1, 1, 2, 0));
		add_row(255, make_box(0, 0, 0, 1600, 1600), 1, make_verdict(0, 2, 2, 0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].thr >= 0) begin
				wait_drained();
				write_threshold(directed_rows[i].thr[8:0]);
			end
			send_box(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int p = 0; p < 6; p++) begin
			sender_idle_pct = (p < 2) ? 32 : (p < 4) ? 76 : 0;
			case (p)
				0: phase_thr = THR_RESET;
				1: phase_thr = 9'd0;
				2: phase_thr = 9'd511;
				3: phase_thr = 9'd256;
				4: phase_thr = $urandom_range(0, 511);
				default: phase_thr = $urandom_range(64, 200);
			endcase
			wait_drained();
			write_threshold(phase_thr);
			sent_mark = boxes_sent;
			while (boxes_sent - sent_mark < 240) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					run_cluster_set();
				else if (pick < 75)
					run_sparse_set();
				else
					run_noise_set();
			end
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (expected_verdicts.size() != 0)
			flag_mismatch("results never arrived", 0, expected_verdicts.size());
		$display("checked %0d results from %0d boxes in %0d sets over %0d threshold settings",
			results_checked, boxes_sent, sets_run, thr_settings);
		$display("%0d kept, %0d suppressed, %0d kept with the store full",
			kept_seen, dropped_seen, overflow_seen);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("timeout with %0d results still expected", expected_verdicts.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
